// ===== sv/int_to_decimal_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_defines
// Assertion macros shared by the integer-to-decimal text block.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ITDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define ITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/itda_pkg.sv =====
// ----------------------------------------------------------------------------
// itda_pkg
// Widths and character codes for the integer-to-decimal text block.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Width of the signed input integer
  localparam int INT_BITS  = 32;
  // Decimal digits needed for the largest magnitude, 2**(INT_BITS-1)
  localparam int DIGITS    = (INT_BITS * 30103) / 100000 + 1;
  localparam int BCD_W     = DIGITS * 4;
  localparam int CNT_W     = $clog2(DIGITS + 1);
  localparam int BIT_CNT_W = $clog2(INT_BITS + 1);

  // ASCII codes
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_NINE  = 7'd57;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

endpackage

// ===== sv/itda_dabble_step.sv =====
// ----------------------------------------------------------------------------
// itda_dabble_step
// One shift-and-add-3 step of binary-to-BCD conversion.
// ----------------------------------------------------------------------------
module itda_dabble_step import itda_pkg::*; (
  input  logic [BCD_W-1:0] bcd_in,
  input  logic             bit_in,
  output logic [BCD_W-1:0] bcd_out
);

  logic [BCD_W-1:0] adj;

  // Correct every digit of five or more, then shift the next bit in
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_in[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_in[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_in[i*4 +: 4];
      end
    end
    bcd_out = {adj[BCD_W-2:0], bit_in};
  end

endmodule

// ===== sv/int_to_decimal_ascii.sv =====
// After acceptance the block runs INT_BITS (32) serial double-dabble steps,
// drops leading zeros one digit per cycle in the skip state, then leaves the
// skip and registers the first character, a minus sign when negative. Digits
// follow one per cycle while the output is not stalled. A new number is taken
// only in idle, after the last digit has entered the output register.
// Reset: synchronous, returns to idle and drops any pending character.
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a signed integer into its decimal ASCII text, one character per
// output transaction, most significant first, with last on the final digit.
// ----------------------------------------------------------------------------
`include "int_to_decimal_ascii_defines.svh"

module int_to_decimal_ascii import itda_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [INT_BITS-1:0] value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [6:0]                 char_code,
  output logic                       last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_SKIP = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]           state;
  logic                 neg;
  logic [INT_BITS-1:0]  mag;
  logic [INT_BITS-1:0]  value_u;
  logic [BCD_W-1:0]     bcd;
  logic [BCD_W-1:0]     bcd_next;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [CNT_W-1:0]     dig_cnt;
  logic [3:0]           top_digit;
  logic                 out_free;
  logic                 char_ok;
  logic                 conv_start;

  assign value_u   = value;
  assign top_digit = bcd[BCD_W-1 -: 4];
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Single conversion step, reused for every input bit
  itda_dabble_step u_step (
    .bcd_in  (bcd),
    .bit_in  (mag[INT_BITS-1]),
    .bcd_out (bcd_next)
  );

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // the emit states load the output register themselves
      if (out_valid && out_ready && !(state inside {S_SIGN, S_EMIT})) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            neg     <= value[INT_BITS-1];
            mag     <= value[INT_BITS-1] ? (~value_u + INT_BITS'(1)) : value_u;
            bcd     <= '0;
            bit_cnt <= BIT_CNT_W'(INT_BITS);
            dig_cnt <= CNT_W'(DIGITS);
            state   <= S_CONV;
          end
        end
        S_CONV: begin
          bcd     <= bcd_next;
          mag     <= {mag[INT_BITS-2:0], 1'b0};
          bit_cnt <= bit_cnt - BIT_CNT_W'(1);
          if (bit_cnt == BIT_CNT_W'(1)) begin
            state <= S_SKIP;
          end
        end
        // drop leading zeros, keeping at least one digit
        S_SKIP: begin
          if (top_digit == 4'd0 && dig_cnt > CNT_W'(1)) begin
            bcd     <= {bcd[BCD_W-5:0], 4'd0};
            dig_cnt <= dig_cnt - CNT_W'(1);
          end else begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= CHAR_MINUS;
            last      <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            char_code <= CHAR_ZERO + {3'd0, top_digit};
            last      <= (dig_cnt == CNT_W'(1));
            bcd       <= {bcd[BCD_W-5:0], 4'd0};
            dig_cnt   <= dig_cnt - CNT_W'(1);
            if (dig_cnt == CNT_W'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  assign char_ok    = (char_code == CHAR_MINUS) ||
                      ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE));
  assign conv_start = (state == S_CONV) && (bit_cnt == BIT_CNT_W'(INT_BITS));

  `ITDA_ASSERT_SAME(a_char_range, out_valid, char_ok, "character outside minus and digits")
  `ITDA_ASSERT_NEXT(a_accept_conv, in_valid && in_ready, conv_start, "number did not start")
  `ITDA_ASSERT_SAME(a_emit_count, state == S_EMIT || state == S_SIGN, dig_cnt != '0, "no digits")

endmodule
